/* rtl/spm_pkg.sv */
// Shared types and constants for the serial poll master with command queue.
// Holds the command codes, register indexes, character codes and queue sizing.
// No dependencies; every other file imports this package.
`default_nettype none

package spm_pkg;

  // Command queue sizing.
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field and register widths.
  localparam int BYTE_W   = 8;
  localparam int POLL_W   = 16;
  localparam int MARGIN_W = 14;
  localparam int SETTLE_W = 14;
  localparam int WDOG_W   = 17;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  // Event codes carried in the input tuser.
  typedef enum logic [IN_USER_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_BYTE  = 3'd1,
    CMD_ALARM = 3'd2,
    CMD_MODE  = 3'd3,
    CMD_START = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_SETTLE  = 2'd2;

  // Register reset values.
  localparam logic [POLL_W-1:0]   POLL_INTERVAL_RST   = 16'd500;
  localparam logic [MARGIN_W-1:0] RESPONSE_MARGIN_RST = 14'd500;
  localparam logic [SETTLE_W-1:0] COMMAND_SETTLE_RST  = 14'd100;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_POLL = 8'h50;
  localparam logic [BYTE_W-1:0] CH_ALARM = 8'h41;
  localparam logic [BYTE_W-1:0] CH_MODE = 8'h46;

  // Result item, packed lowest field first (struct order is msb first).
  typedef struct packed {
    logic              dropped;
    logic              busy_res;
    logic              timed_out;
    logic              line_end;
    logic [BYTE_W-1:0] line_byte;
    logic              line_byte_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_valid;
  } result_t;

endpackage

`default_nettype wire

/* rtl/serial_poll_master_with_cmd_queue.sv */
// Top level of the serial poll master: line framing, poll/watchdog/settle
// timers and the alarm/mode command queue, with one result per event.
// Depends on spm_pkg.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------
//  s_*      | in        | s_tvalid / s_tready | tdata: rx_byte, link_open; tuser: cmd
//  m_*      | out       | m_tvalid / m_tready | tdata: result fields (see port)
//  cfg_*    | in        | cfg_we              | cfg_addr selects register
//
// Each event is accepted and fully processed combinationally; its result sits in
// the output register the next cycle. One event per cycle is sustained unless stalled.
// The input is stalled only while the output register holds an untaken result.
// Synchronous reset clears all control state and loads register defaults;
// the queue entries themselves are not cleared.
`default_nettype none

module serial_poll_master_with_cmd_queue (
  input  wire                                  clk,
  input  wire                                  rst,
  // Configuration write port.
  input  wire                                  cfg_we,
  input  wire  [spm_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire  [spm_pkg::CFG_W-1:0]            cfg_wdata,
  // Event input.
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [spm_pkg::IN_DATA_W-1:0]        s_tdata,  // [7:0] rx_byte, [8] link_open
  input  wire  [spm_pkg::IN_USER_W-1:0]        s_tuser,  // [2:0] cmd
  // Result output.
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] line_byte_valid, [17:10] line_byte,
  // [18] line_end, [19] timed_out, [20] busy_res, [21] dropped
  output logic [spm_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import spm_pkg::*;

  // Configuration registers.
  logic [POLL_W-1:0]   poll_interval;
  logic [MARGIN_W-1:0] response_margin;
  logic [SETTLE_W-1:0] command_settle;

  // Control state.
  logic                polling_on, polling_on_next;
  logic                line_busy, line_busy_next;
  logic                in_line, in_line_next;
  logic [POLL_W-1:0]   poll_count, poll_count_next;
  logic                wdog_armed, wdog_armed_next;
  logic [WDOG_W-1:0]   wdog_count, wdog_count_next;
  logic                settle_armed, settle_armed_next;
  logic [SETTLE_W-1:0] settle_count, settle_count_next;
  logic [PTR_W-1:0]    fifo_head, fifo_head_next;
  logic [CNT_W-1:0]    fifo_count, fifo_count_next;

  // Queue storage: one bit per entry, set for a mode toggle request.
  logic                fifo_mem [QUEUE_DEPTH];
  logic                fifo_we;
  logic [PTR_W-1:0]    fifo_waddr;
  logic                fifo_wdata;

  // Output register.
  result_t             res, res_next;
  logic                accept;

  // Event decode.
  cmd_t                cmd;
  logic [BYTE_W-1:0]   rx_byte;
  logic                link_open;

  assign cmd       = cmd_t'(s_tuser);
  assign rx_byte   = s_tdata[BYTE_W-1:0];
  assign link_open = s_tdata[BYTE_W];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = OUT_DATA_W'(res);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval   <= POLL_INTERVAL_RST;
      response_margin <= RESPONSE_MARGIN_RST;
      command_settle  <= COMMAND_SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POLL_INTERVAL:   poll_interval   <= cfg_wdata[POLL_W-1:0];
        REG_RESPONSE_MARGIN: response_margin <= cfg_wdata[MARGIN_W-1:0];
        REG_COMMAND_SETTLE:  command_settle  <= cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Event processing: all state updates and the result for one event.
  always_comb begin
    logic [CNT_W:0]    wsum;
    logic [POLL_W:0]   poll_sum;
    logic              code;
    logic              disp_req;
    logic              is_semi;
    logic              is_eol;

    polling_on_next   = polling_on;
    line_busy_next    = line_busy;
    in_line_next      = in_line;
    poll_count_next   = poll_count;
    wdog_armed_next   = wdog_armed;
    wdog_count_next   = wdog_count;
    settle_armed_next = settle_armed;
    settle_count_next = settle_count;
    fifo_head_next    = fifo_head;
    fifo_count_next   = fifo_count;
    res_next          = '0;
    disp_req          = 1'b0;

    // Enqueue address, wrapped without a divider (sum stays below twice the depth).
    wsum = (CNT_W+1)'(fifo_head) + (CNT_W+1)'(fifo_count);
    if (wsum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      wsum = wsum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    fifo_waddr = wsum[PTR_W-1:0];
    fifo_wdata = (cmd == CMD_MODE);
    fifo_we    = 1'b0;

    is_semi  = (rx_byte == CH_SEMI);
    is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    poll_sum = {1'b0, poll_count} + (POLL_W+1)'(1);

    case (cmd)
      CMD_TICK: begin
        // Watchdog first.
        if (wdog_armed) begin
          if (wdog_count <= WDOG_W'(1)) begin
            wdog_armed_next    = 1'b0;
            wdog_count_next    = '0;
            line_busy_next     = 1'b0;
            res_next.timed_out = 1'b1;
            disp_req           = 1'b1;
          end else begin
            wdog_count_next = wdog_count - WDOG_W'(1);
          end
        end
      end
      CMD_BYTE: begin
        // Line framing: ';' opens a line, CR/LF/';' close an open one.
        if (in_line && (is_semi || is_eol)) begin
          res_next.line_end = 1'b1;
          in_line_next      = 1'b0;
          line_busy_next    = 1'b0;
          wdog_armed_next   = 1'b0;
          wdog_count_next   = '0;
          disp_req          = 1'b1;
        end
        if (is_semi) begin
          in_line_next = 1'b1;
        end
        if (is_semi || (in_line && !is_eol)) begin
          res_next.line_byte_valid = 1'b1;
          res_next.line_byte       = rx_byte;
        end
      end
      CMD_ALARM, CMD_MODE: begin
        if (fifo_count >= CNT_W'(QUEUE_DEPTH)) begin
          res_next.dropped = 1'b1;
        end else begin
          fifo_we         = 1'b1;
          fifo_count_next = fifo_count + CNT_W'(1);
        end
        disp_req = 1'b1;
      end
      CMD_START: begin
        polling_on_next  = 1'b1;
        in_line_next     = 1'b0;
        fifo_head_next   = '0;
        fifo_count_next  = '0;
        poll_count_next  = '0;
        res_next.tx_valid = 1'b1;
        res_next.tx_byte  = CH_POLL;
        line_busy_next   = 1'b1;
        wdog_armed_next  = 1'b1;
        wdog_count_next  = WDOG_W'(poll_interval) + WDOG_W'(response_margin);
      end
      CMD_STOP: begin
        polling_on_next   = 1'b0;
        poll_count_next   = '0;
        wdog_armed_next   = 1'b0;
        wdog_count_next   = '0;
        settle_armed_next = 1'b0;
        settle_count_next = '0;
        line_busy_next    = 1'b0;
        fifo_head_next    = '0;
        fifo_count_next   = '0;
      end
      default: ;
    endcase

    // Dispatch the oldest request onto an idle line. An entry written this
    // step is read straight from the write side.
    code = (fifo_we && (fifo_count == '0)) ? fifo_wdata : fifo_mem[fifo_head];
    if (disp_req && !line_busy_next && (fifo_count_next != '0)) begin
      res_next.tx_valid = 1'b1;
      res_next.tx_byte  = code ? CH_MODE : CH_ALARM;
      fifo_head_next    = (fifo_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : fifo_head + PTR_W'(1);
      fifo_count_next   = fifo_count_next - CNT_W'(1);
      line_busy_next    = 1'b1;
      settle_armed_next = 1'b1;
      settle_count_next = command_settle;
    end

    if (cmd == CMD_TICK) begin
      // Settle timer second; held for a tick if the line was just used.
      if (settle_armed_next) begin
        if (res_next.tx_valid) begin
          settle_count_next = (settle_count_next <= SETTLE_W'(1)) ? SETTLE_W'(1)
                                                                  : settle_count_next - SETTLE_W'(1);
        end else if (settle_count_next <= SETTLE_W'(1)) begin
          settle_count_next = '0;
          settle_armed_next = 1'b0;
          if (link_open) begin
            res_next.tx_valid = 1'b1;
            res_next.tx_byte  = CH_POLL;
            line_busy_next    = 1'b1;
            wdog_armed_next   = 1'b1;
            wdog_count_next   = WDOG_W'(poll_interval) + WDOG_W'(response_margin);
          end else begin
            line_busy_next = 1'b0;
          end
        end else begin
          settle_count_next = settle_count_next - SETTLE_W'(1);
        end
      end
      // Periodic poll last.
      if (polling_on) begin
        if (poll_sum >= {1'b0, poll_interval}) begin
          poll_count_next = '0;
          if (link_open && !line_busy_next) begin
            res_next.tx_valid = 1'b1;
            res_next.tx_byte  = CH_POLL;
            line_busy_next    = 1'b1;
            wdog_armed_next   = 1'b1;
            wdog_count_next   = WDOG_W'(poll_interval) + WDOG_W'(response_margin);
          end
        end else begin
          poll_count_next = poll_sum[POLL_W-1:0];
        end
      end
    end

    res_next.busy_res = line_busy_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      polling_on   <= 1'b0;
      line_busy    <= 1'b0;
      in_line      <= 1'b0;
      poll_count   <= '0;
      wdog_armed   <= 1'b0;
      wdog_count   <= '0;
      settle_armed <= 1'b0;
      settle_count <= '0;
      fifo_head    <= '0;
      fifo_count   <= '0;
    end else if (accept) begin
      polling_on   <= polling_on_next;
      line_busy    <= line_busy_next;
      in_line      <= in_line_next;
      poll_count   <= poll_count_next;
      wdog_armed   <= wdog_armed_next;
      wdog_count   <= wdog_count_next;
      settle_armed <= settle_armed_next;
      settle_count <= settle_count_next;
      fifo_head    <= fifo_head_next;
      fifo_count   <= fifo_count_next;
    end
  end

  // Queue storage write.
  always_ff @(posedge clk) begin
    if (accept && fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/spm_checker.sv */
// Port-level checker for the serial poll master, bound to the top level.
// Watches the output stream and the input handshake only.
// Depends on spm_pkg.
`default_nettype none

module spm_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_tready,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [spm_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import spm_pkg::*;

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The output side is empty right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Every transmission leaves the line busy.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[20])
    else $error("transmit without line busy");

  // Byte fields are zero when their valid flags are low.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || (m_tdata[8:1] == '0)) &&
                 (m_tdata[9] || (m_tdata[17:10] == '0)))
    else $error("byte field set without its valid flag");

  // An empty output register never blocks the input.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind serial_poll_master_with_cmd_queue spm_checker u_spm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* verif/spm_result_monitor.sv */
`timescale 1ns / 100ps
// Result monitor for the serial poll master: watches the event, result and
// register-write channels, predicts every result and compares it field by field.
// Depends on spm_pkg for widths, event codes, register indexes and the result layout.

module spm_result_monitor (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [spm_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire  [spm_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                              s_tvalid,
  input  wire                              s_tready,
  input  wire  [spm_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] rx_byte, [8] link_open
  input  wire  [spm_pkg::IN_USER_W-1:0]    s_tuser,  // [2:0] cmd
  input  wire                              m_tvalid,
  input  wire                              m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] line_byte_valid, [17:10] line_byte,
  // [18] line_end, [19] timed_out, [20] busy_res, [21] dropped
  input  wire  [spm_pkg::OUT_DATA_W-1:0]   m_tdata,
  output int                               outstanding,
  output int                               mismatch_count
);

  import spm_pkg::*;

  // Timer settings as last written.
  logic [POLL_W-1:0]   poll_interval;
  logic [MARGIN_W-1:0] resp_margin;
  logic [SETTLE_W-1:0] settle_ms;

  // Mirror of the block's control state.
  logic                polling_on;
  logic                line_busy;
  logic                in_line;
  logic [WDOG_W-1:0]   poll_count;
  logic                wd_armed;
  logic [WDOG_W-1:0]   wd_count;
  logic                settle_armed;
  logic [SETTLE_W-1:0] settle_count;
  logic                queued_mode [QUEUE_DEPTH];  // 1 = mode toggle, 0 = alarm step
  logic [PTR_W-1:0]    q_head;
  logic [CNT_W-1:0]    q_count;

  // Transmission made during the event being predicted.
  logic                tx_now;
  logic [BYTE_W-1:0]   tx_code;

  result_t owed_results [$];
  int      mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic void transmit(input logic [BYTE_W-1:0] code);
    tx_now  = 1'b1;
    tx_code = code;
  endfunction

  // A poll holds the line and arms the response watchdog.
  function automatic void send_poll();
    transmit(CH_POLL);
    line_busy = 1'b1;
    wd_armed  = 1'b1;
    wd_count  = {1'b0, poll_interval} + WDOG_W'(resp_margin);
  endfunction

  // The oldest queued request goes out only on an idle line.
  function automatic void try_dispatch();
    if (line_busy || q_count == 0) return;
    transmit(queued_mode[q_head] ? CH_MODE : CH_ALARM);
    q_head       = PTR_W'((int'(q_head) + 1) % QUEUE_DEPTH);
    q_count      = q_count - 1'b1;
    line_busy    = 1'b1;
    settle_armed = 1'b1;
    settle_count = settle_ms;
  endfunction

  // Applies one event to the mirrored state and returns the result it causes.
  function automatic result_t step_poll_master(input logic [IN_USER_W-1:0] cmd,
                                               input logic [BYTE_W-1:0] rx,
                                               input logic link);
    result_t r;
    logic    closing;
    r       = '0;
    closing = 1'b0;
    tx_now  = 1'b0;
    tx_code = '0;
    case (cmd)
      CMD_TICK: begin
        // Watchdog first; its expiry frees the line and may send a request.
        if (wd_armed) begin
          if (wd_count <= 1) begin
            wd_count    = '0;
            wd_armed    = 1'b0;
            line_busy   = 1'b0;
            r.timed_out = 1'b1;
            try_dispatch();
          end else begin
            wd_count = wd_count - 1'b1;
          end
        end
        // Settle timer; its expiry waits a tick if something already went out.
        if (settle_armed) begin
          if (tx_now) begin
            settle_count = (settle_count <= 1) ? SETTLE_W'(1) : settle_count - 1'b1;
          end else if (settle_count <= 1) begin
            settle_count = '0;
            settle_armed = 1'b0;
            if (link) send_poll();
            else line_busy = 1'b0;
          end else begin
            settle_count = settle_count - 1'b1;
          end
        end
        // Periodic poll last.
        if (polling_on) begin
          poll_count = poll_count + 1'b1;
          if (poll_count >= {1'b0, poll_interval}) begin
            poll_count = '0;
            if (link && !line_busy) send_poll();
          end
        end
      end
      CMD_BYTE: begin
        if (in_line && (rx == CH_SEMI || rx == CH_CR || rx == CH_LF)) begin
          closing = 1'b1;
          in_line = 1'b0;
        end
        if (rx == CH_SEMI) begin
          in_line           = 1'b1;
          r.line_byte_valid = 1'b1;
          r.line_byte       = rx;
        end else if (in_line) begin
          r.line_byte_valid = 1'b1;
          r.line_byte       = rx;
        end
        if (closing) begin
          r.line_end = 1'b1;
          line_busy  = 1'b0;
          wd_armed   = 1'b0;
          wd_count   = '0;
          try_dispatch();
        end
      end
      CMD_ALARM, CMD_MODE: begin
        if (q_count >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          queued_mode[(int'(q_head) + int'(q_count)) % QUEUE_DEPTH] = (cmd == CMD_MODE);
          q_count = q_count + 1'b1;
        end
        try_dispatch();
      end
      CMD_START: begin
        polling_on = 1'b1;
        line_busy  = 1'b0;
        in_line    = 1'b0;
        q_head     = '0;
        q_count    = '0;
        poll_count = '0;
        send_poll();
      end
      CMD_STOP: begin
        polling_on   = 1'b0;
        poll_count   = '0;
        wd_armed     = 1'b0;
        wd_count     = '0;
        settle_armed = 1'b0;
        settle_count = '0;
        line_busy    = 1'b0;
        q_head       = '0;
        q_count      = '0;
      end
      default: ;
    endcase
    r.tx_valid = tx_now;
    r.tx_byte  = tx_code;
    r.busy_res = line_busy;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Track register writes, predict on each accepted event and compare on each
  // accepted result. Results are taken before events so that a result never
  // matches an event accepted on the same edge.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      poll_interval = POLL_INTERVAL_RST;
      resp_margin   = RESPONSE_MARGIN_RST;
      settle_ms     = COMMAND_SETTLE_RST;
      polling_on    = 1'b0;
      line_busy     = 1'b0;
      in_line       = 1'b0;
      poll_count    = '0;
      wd_armed      = 1'b0;
      wd_count      = '0;
      settle_armed  = 1'b0;
      settle_count  = '0;
      q_head        = '0;
      q_count       = '0;
      owed_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_POLL_INTERVAL:   poll_interval = cfg_wdata[POLL_W-1:0];
          REG_RESPONSE_MARGIN: resp_margin   = cfg_wdata[MARGIN_W-1:0];
          REG_COMMAND_SETTLE:  settle_ms     = cfg_wdata[SETTLE_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (owed_results.size() == 0) begin
          $error("result transaction with nothing outstanding: %h", m_tdata);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("tx_valid", BYTE_W'(want.tx_valid), BYTE_W'(got.tx_valid));
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("line_byte_valid", BYTE_W'(want.line_byte_valid),
                      BYTE_W'(got.line_byte_valid));
          check_field("line_byte", want.line_byte, got.line_byte);
          check_field("line_end", BYTE_W'(want.line_end), BYTE_W'(got.line_end));
          check_field("timed_out", BYTE_W'(want.timed_out), BYTE_W'(got.timed_out));
          check_field("busy_res", BYTE_W'(want.busy_res), BYTE_W'(got.busy_res));
          check_field("dropped", BYTE_W'(want.dropped), BYTE_W'(got.dropped));
        end
      end
      if (s_tvalid && s_tready)
        owed_results.push_back(step_poll_master(s_tuser, s_tdata[7:0], s_tdata[8]));
      outstanding <= owed_results.size();
    end
  end

endmodule

/* verif/serial_poll_master_with_cmd_queue_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the serial poll master: drives events and register writes,
// throttles the result channel and gives the verdict.
// Depends on spm_pkg, the block itself and spm_result_monitor.

module serial_poll_master_with_cmd_queue_tb;

  import spm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Event codes the block ignores.
  localparam logic [IN_USER_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [IN_USER_W-1:0] CMD_UNUSED_HI = 3'd7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] rx_byte, [8] link_open
  logic [IN_USER_W-1:0]  s_tuser = '0;   // [2:0] cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [0] tx_valid, [8:1] tx_byte, [9] line_byte_valid, [17:10] line_byte,
  // [18] line_end, [19] timed_out, [20] busy_res, [21] dropped
  logic [OUT_DATA_W-1:0] m_tdata;

  int outstanding;
  int mismatch_count;
  int cycle_count = 0;
  int source_gap_pct = 0;
  int sink_stall_pct = 0;

  serial_poll_master_with_cmd_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  spm_result_monitor i_monitor (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result channel back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("serial_poll_master_with_cmd_queue_tb: errors");
    $finish;
  end

  // One event transaction, with random idle cycles ahead of it.
  task automatic send_event(input logic [IN_USER_W-1:0] cmd, input logic [BYTE_W-1:0] rx,
                            input logic link);
    while ($urandom_range(0, 99) < source_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, link, rx};
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold off new events until every predicted result has come back.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_timers(input logic [POLL_W-1:0] poll,
                                input logic [MARGIN_W-1:0] margin,
                                input logic [SETTLE_W-1:0] settle);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_POLL_INTERVAL;
    cfg_wdata <= CFG_W'(poll);
    @(posedge clk);
    cfg_addr  <= REG_RESPONSE_MARGIN;
    cfg_wdata <= CFG_W'(margin);
    @(posedge clk);
    cfg_addr  <= REG_COMMAND_SETTLE;
    cfg_wdata <= CFG_W'(settle);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed traffic: tick runs, reply lines and request bursts,
  // mixed with starts, stops, stray bytes and ignored codes.
  task automatic random_traffic(input int n_items);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          send_event(CMD_TICK, 8'($urandom), $urandom_range(0, 99) < 85);
          done++;
        end
      end else if (pick < 65) begin
        // Reply line, sometimes left open.
        send_event(CMD_BYTE, CH_SEMI, 1'($urandom_range(0, 1)));
        len = $urandom_range(0, 4);
        repeat (len) send_event(CMD_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
        done += len + 1;
        case ($urandom_range(0, 3))
          0: begin send_event(CMD_BYTE, CH_CR, 1'b1); done++; end
          1: begin send_event(CMD_BYTE, CH_LF, 1'b0); done++; end
          2: begin send_event(CMD_BYTE, CH_SEMI, 1'b1); done++; end
          default: ;
        endcase
      end else if (pick < 78) begin
        // Occasional long bursts overflow the queue while the line is busy.
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 2);
        repeat (len) begin
          send_event($urandom_range(0, 1) ? CMD_MODE : CMD_ALARM, 8'($urandom),
                     1'($urandom_range(0, 1)));
          done++;
        end
      end else if (pick < 84) begin
        send_event(CMD_START, 8'($urandom), $urandom_range(0, 99) < 85);
        done++;
      end else if (pick < 87) begin
        send_event(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
        done++;
      end else if (pick < 95) begin
        send_event(CMD_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
        done++;
      end else begin
        send_event($urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO, 8'($urandom),
                   1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int n_items;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    program_timers(16'd10, 14'd0, 14'd0);

    // Directed: framing, ignored codes, start without a link, queued requests
    // released by a watchdog expiry, a settle expiry held for one tick, a
    // settle expiry without a link, and stop.
    send_event(CMD_TICK, 8'h00, 1'b1);
    send_event(CMD_BYTE, 8'h00, 1'b1);
    send_event(CMD_BYTE, CH_SEMI, 1'b1);
    send_event(CMD_BYTE, 8'hFF, 1'b0);
    send_event(CMD_BYTE, CH_SEMI, 1'b1);
    send_event(CMD_BYTE, CH_CR, 1'b1);
    send_event(CMD_UNUSED_LO, 8'hAA, 1'b1);
    send_event(CMD_START, 8'h55, 1'b0);
    send_event(CMD_ALARM, 8'h00, 1'b1);
    send_event(CMD_MODE, 8'hFF, 1'b1);
    repeat (11) send_event(CMD_TICK, 8'h00, 1'b1);
    send_event(CMD_BYTE, CH_SEMI, 1'b1);
    send_event(CMD_BYTE, CH_LF, 1'b1);
    send_event(CMD_TICK, 8'h00, 1'b0);
    send_event(CMD_STOP, 8'h00, 1'b1);

    // Random phases over several timer settings and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      case (ph)
        0: program_timers(16'd10, 14'd0, 14'd0);
        1: program_timers(16'd14, 14'd6, 14'd3);
        2: program_timers(16'd60000, 14'd10000, 14'd10000);
        3: program_timers(16'd11, 14'd2, 14'd1);
        4: program_timers(16'd25, 14'd20, 14'd9);
        default: program_timers(16'd12, 14'd9, 14'd4);
      endcase
      case (ph % 3)
        0: begin source_gap_pct = 21; sink_stall_pct = 51; end
        1: begin source_gap_pct = 51; sink_stall_pct = 21; end
        default: begin source_gap_pct = 0; sink_stall_pct = 0; end
      endcase
      n_items = (ph == 2) ? 40 : 150;
      random_traffic(n_items / 2);
      wait_quiet();
      random_traffic(n_items - n_items / 2);
    end

    wait_quiet();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("serial_poll_master_with_cmd_queue_tb: clean");
    else
      $display("serial_poll_master_with_cmd_queue_tb: errors");
    $finish;
  end

endmodule
